FILE: sv/interrupt_pending_mask_controller_top_assert.svh
// assertion macros used by the interrupt controller checker
`ifndef INTERRUPT_PENDING_MASK_CONTROLLER_TOP_ASSERT_SVH
`define INTERRUPT_PENDING_MASK_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define IPMC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define IPMC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/ipmc_pkg.sv
package ipmc_pkg;

   // field widths of the request and response words
   localparam int OP_W       = 2;
   localparam int ADDR_W     = 12;
   localparam int DATA_W     = 32;
   localparam int SRC_W      = 4;
   localparam int FIRING_W   = 16;

   // address layout: region in bits 11:10, source index in bits 9:2
   localparam int IDX_W      = 8;
   localparam int IDX_LSB    = 2;
   localparam int REGION_LSB = 10;

   typedef enum logic [OP_W-1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_FLAG  = 2'd2,
      OP_TICK  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REGION_FIRING  = 2'd0,
      REGION_PENDING = 2'd1,
      REGION_ENABLE  = 2'd2,
      REGION_SPARE   = 2'd3
   } region_type;

   // decoded request word handed from the input stage to the bank
   typedef struct packed {
      logic              rd;
      logic              clr_pend;
      logic              set_en;
      logic              flag;
      logic              tick;
      region_type        region;
      logic [IDX_W-1:0]  idx;
      logic [DATA_W-1:0] wdata;
      logic [SRC_W-1:0]  source;
      logic [DATA_W-1:0] flags;
      logic              int_enable;
   } cmd_type;

endpackage

FILE: sv/ipmc_decode.sv
module ipmc_decode
   import ipmc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [OP_W-1:0]   req_op,
   input  logic [ADDR_W-1:0] req_addr,
   input  logic [DATA_W-1:0] req_wdata,
   input  logic [SRC_W-1:0]  req_source,
   input  logic [DATA_W-1:0] req_flags,
   input  logic              req_int_enable,
   output logic              cmd_valid,
   output cmd_type           cmd
);

   cmd_type cmd_in;
   cmd_type cmd_ff;
   logic    cmd_valid_ff;

   // split the request word into operation strobes and address fields
   always_comb begin
      cmd_in            = '0;
      cmd_in.region     = region_type'(req_addr[REGION_LSB +: 2]);
      cmd_in.idx        = req_addr[IDX_LSB +: IDX_W];
      cmd_in.wdata      = req_wdata;
      cmd_in.source     = req_source;
      cmd_in.flags      = req_flags;
      cmd_in.int_enable = req_int_enable;
      unique case (op_type'(req_op))
         OP_READ: begin
            cmd_in.rd = 1'b1;
         end
         OP_WRITE: begin
            cmd_in.clr_pend = (cmd_in.region == REGION_PENDING);
            cmd_in.set_en   = (cmd_in.region == REGION_ENABLE);
         end
         OP_FLAG: begin
            cmd_in.flag = 1'b1;
         end
         OP_TICK: begin
            cmd_in.tick = 1'b1;
         end
         default: begin
            cmd_in.rd = 1'b0;
         end
      endcase
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= accept;
      end
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = cmd_valid_ff;
   assign cmd       = cmd_ff;

endmodule

FILE: sv/ipmc_bank.sv
module ipmc_bank
   import ipmc_pkg::*;
#(
   parameter int NUM_SOURCES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  cmd_type             cmd,
   output logic [DATA_W-1:0]   rdata,
   output logic                fired,
   output logic [FIRING_W-1:0] firing
);

   logic [DATA_W-1:0]   pending_ff [NUM_SOURCES];
   logic [DATA_W-1:0]   pending_in [NUM_SOURCES];
   logic [DATA_W-1:0]   enable_ff  [NUM_SOURCES];
   logic [DATA_W-1:0]   enable_in  [NUM_SOURCES];
   logic [NUM_SOURCES-1:0] bus_hit;
   logic [NUM_SOURCES-1:0] flag_hit;
   logic [FIRING_W-1:0] firing_ff;
   logic [FIRING_W-1:0] firing_in;
   logic [DATA_W-1:0]   pend_sel;
   logic [DATA_W-1:0]   en_sel;

   // per-source update of the pending and enable words
   for (genvar i = 0; i < NUM_SOURCES; i++) begin : g_src
      assign bus_hit[i] = (cmd.idx == IDX_W'(i));
      if (i < (1 << SRC_W)) begin : g_flag
         assign flag_hit[i] = (cmd.source == SRC_W'(i));
      end else begin : g_noflag
         assign flag_hit[i] = 1'b0;
      end

      always_comb begin
         pending_in[i] = pending_ff[i];
         enable_in[i]  = enable_ff[i];
         if (cmd_valid && cmd.clr_pend && bus_hit[i]) begin
            pending_in[i] = pending_ff[i] & ~cmd.wdata;
         end
         if (cmd_valid && cmd.flag && flag_hit[i]) begin
            pending_in[i] = pending_ff[i] | cmd.flags;
         end
         if (cmd_valid && cmd.set_en && bus_hit[i]) begin
            enable_in[i] = cmd.wdata;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            pending_ff[i] <= '0;
            enable_ff[i]  <= '0;
         end else begin
            pending_ff[i] <= pending_in[i];
            enable_ff[i]  <= enable_in[i];
         end
      end
   end

   // firing bit per source, only the first sixteen sources report
   for (genvar b = 0; b < FIRING_W; b++) begin : g_fire
      if (b < NUM_SOURCES) begin : g_live
         assign firing_in[b] = |(pending_in[b] & enable_in[b]);
      end else begin : g_dead
         assign firing_in[b] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         firing_ff <= '0;
      end else begin
         firing_ff <= firing_in;
      end
   end

   // read select over the addressed source, zero when out of range
   always_comb begin
      pend_sel = '0;
      en_sel   = '0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
         pend_sel = pend_sel | (bus_hit[i] ? pending_ff[i] : '0);
         en_sel   = en_sel   | (bus_hit[i] ? enable_ff[i]  : '0);
      end
   end

   always_comb begin
      rdata = '0;
      if (cmd_valid && cmd.rd) begin
         unique case (cmd.region)
            REGION_FIRING: begin
               rdata = (cmd.idx == '0) ? DATA_W'(firing_ff) : '0;
            end
            REGION_PENDING: begin
               rdata = pend_sel;
            end
            REGION_ENABLE: begin
               rdata = en_sel;
            end
            default: begin
               rdata = '0;
            end
         endcase
      end
   end

   // tick reports against the vector after this word
   assign fired  = cmd_valid && cmd.tick && cmd.int_enable && (|firing_in);
   assign firing = firing_ff;

endmodule

FILE: sv/interrupt_pending_mask_controller_top.sv
// a word taken at an edge passes the input register, then the response register, which gives its response strobe
// throughput: one word per cycle, busy is low from the first edge after reset is released
// and the receiver cannot stall
// reset: synchronous, active high; clears all pending and enable words and the firing vector,
// holds busy high until the first edge after release, and drops any word in flight
module interrupt_pending_mask_controller_top
   import ipmc_pkg::*;
#(
   parameter int NUM_SOURCES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [OP_W-1:0]     req_op,
   input  logic [ADDR_W-1:0]   req_addr,
   input  logic [DATA_W-1:0]   req_wdata,
   input  logic [SRC_W-1:0]    req_source,
   input  logic [DATA_W-1:0]   req_flags,
   input  logic                req_int_enable,
   output logic                rsp_valid,
   output logic [DATA_W-1:0]   rsp_rdata,
   output logic [FIRING_W-1:0] rsp_firing,
   output logic                rsp_irq_taken
);

   logic                accept;
   logic                busy_ff;
   logic                cmd_valid;
   cmd_type             cmd;
   logic [DATA_W-1:0]   rdata;
   logic                fired;
   logic [FIRING_W-1:0] firing;
   logic                rsp_valid_ff;
   logic [DATA_W-1:0]   rsp_rdata_ff;
   logic                rsp_irq_taken_ff;

   assign accept = start && !busy_ff;

   ipmc_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_op         (req_op),
      .req_addr       (req_addr),
      .req_wdata      (req_wdata),
      .req_source     (req_source),
      .req_flags      (req_flags),
      .req_int_enable (req_int_enable),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd)
   );

   ipmc_bank #(
      .NUM_SOURCES (NUM_SOURCES)
   ) u_bank (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .rdata     (rdata),
      .fired     (fired),
      .firing    (firing)
   );

   // busy only while held in reset, response register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff          <= 1'b1;
         rsp_valid_ff     <= 1'b0;
         rsp_rdata_ff     <= '0;
         rsp_irq_taken_ff <= 1'b0;
      end else begin
         busy_ff          <= 1'b0;
         rsp_valid_ff     <= cmd_valid;
         rsp_rdata_ff     <= rdata;
         rsp_irq_taken_ff <= fired;
      end
   end

   assign busy          = busy_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rdata     = rsp_rdata_ff;
   assign rsp_firing    = firing;
   assign rsp_irq_taken = rsp_irq_taken_ff;

endmodule

FILE: sv/ipmc_checker.sv
`include "interrupt_pending_mask_controller_top_assert.svh"

module ipmc_checker
   import ipmc_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic [OP_W-1:0]     req_op,
   input logic                req_int_enable,
   input logic                rsp_valid,
   input logic [DATA_W-1:0]   rsp_rdata,
   input logic [FIRING_W-1:0] rsp_firing,
   input logic                rsp_irq_taken
);

   // every accepted word is followed by a response strobe from the response register
   `IPMC_ASSERT_NEXT(a_rsp_follows, clock, reset, start && !busy, ##1 rsp_valid,
                     "response missing")

   // an interrupt is only reported with a nonzero firing vector
   `IPMC_ASSERT_NOW(a_fired_vector, clock, reset, rsp_valid && rsp_irq_taken,
                    rsp_firing != '0, "fired with empty vector")

   // an interrupt is only reported for a tick word with the cpu enable set
   `IPMC_ASSERT_NOW(a_fired_tick, clock, reset, rsp_irq_taken,
                    rsp_valid && ($past(req_op, 2) == OP_TICK) && $past(req_int_enable, 2),
                    "fired without enabled tick")

   // read data stays zero for anything but a bus read
   `IPMC_ASSERT_NOW(a_rdata_zero, clock, reset, rsp_valid && ($past(req_op, 2) != OP_READ),
                    rsp_rdata == '0, "read data on non-read word")

endmodule

bind interrupt_pending_mask_controller_top ipmc_checker u_ipmc_checker (.*);
